>>> rtl/sorted_key_cache_lookup_insert_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key cache
// Clocked implication checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_CACHE_LOOKUP_INSERT_ASSERT_SVH
`define SORTED_KEY_CACHE_LOOKUP_INSERT_ASSERT_SVH

// same-cycle implication
`define SKC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication
`define SKC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

>>> rtl/skcli_pkg.sv
// ----------------------------------------------------------------------------
// skcli_pkg
// Shared constants and types of the sorted key cache.
// ----------------------------------------------------------------------------
`default_nettype none

package skcli_pkg;

    localparam int KEY_W   = 21;
    localparam int GLYPH_W = 32;
    localparam int SLOT_W  = 8;

    // per-cycle command from the sequencer to every cell
    typedef struct packed {
        logic cmp;   // latch compare flags against the request key
        logic ins;   // shift up / load new entry
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/sorted_key_cache_lookup_insert.sv
// ----------------------------------------------------------------------------
// sorted_key_cache_lookup_insert
// Sorted key/payload table with lookup and ordered insert in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one request word: tdata = {payload, key}, tuser =
//   load_ok. Master channel returns one result word per request: tdata =
//   {glyph_out, slot}, tuser = {use_missing, inserted, hit}.
//   Every slot is a cell; all cells compare against the request key together
//   in the compare step (S_CMP), then on an insert every cell above the
//   insertion point takes its lower neighbor's entry in the update step.
//   The result is registered in the output register when the update step
//   (S_UPD) commits; a new word is accepted only in the idle state or as
//   the previous word commits from the update step of the cell chain.
//   Reset empties the table at once (entry count to zero); no clearing pass.
//   A stalled master side holds its result; the block then finishes the
//   compare of the next word and waits in the update step until the output
//   register frees, leaving the table untouched until then.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_cache_lookup_insert_assert.svh"

module sorted_key_cache_lookup_insert
    import skcli_pkg::*;
#(
    parameter int CAPACITY     = 256,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // key[20:0], payload[52:21], zero pad
    input  wire logic        s_axis_tuser,   // load_ok
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // slot[7:0], glyph_out[39:8]
    output logic [2:0]       m_axis_tuser    // hit, inserted, use_missing
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int PW    = PAYLOAD_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [KEY_W-1:0] r_key;
    logic [PW-1:0]    r_pld;
    logic             r_ok;
    logic [CNT_W-1:0] r_count;

    logic             r_out_valid;
    logic [2:0]       r_out_flags;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [GLYPH_W-1:0] r_out_glyph;

    logic             w_accept;
    logic             w_commit;
    logic             w_out_free;
    logic             w_hit;
    logic             w_full;
    logic             w_do_ins;
    t_cell_ctl        w_ctl;
    logic [PW-1:0]    w_in_pld;

    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_prev_lt;
    logic [CAPACITY-1:0] w_sel;
    logic [KEY_W-1:0]    w_cell_key [CAPACITY];
    logic [PW-1:0]       w_cell_pld [CAPACITY];

    logic [IW-1:0]       w_pos;
    logic [PW-1:0]       w_hit_pld;
    logic [PW-1:0]       w_res_pld;
    logic [SLOT_W-1:0]   w_slot8;
    logic [GLYPH_W-1:0]  w_glyph32;

    // ---- payload width adaption
    generate
        if (PW <= GLYPH_W) begin : g_pin_narrow
            assign w_in_pld = s_axis_tdata[KEY_W +: PW];
        end else begin : g_pin_wide
            assign w_in_pld = {{(PW-GLYPH_W){1'b0}}, s_axis_tdata[KEY_W +: GLYPH_W]};
        end
        if (PW >= GLYPH_W) begin : g_pout_wide
            assign w_glyph32 = w_res_pld[GLYPH_W-1:0];
        end else begin : g_pout_narrow
            assign w_glyph32 = {{(GLYPH_W-PW){1'b0}}, w_res_pld};
        end
        if (IW >= SLOT_W) begin : g_slot_wide
            assign w_slot8 = w_pos[SLOT_W-1:0];
        end else begin : g_slot_narrow
            assign w_slot8 = {{(SLOT_W-IW){1'b0}}, w_pos};
        end
    endgenerate

    // ---- handshake and sequencing
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_commit      = (r_state == S_UPD) && w_out_free;
    assign s_axis_tready = (r_state == S_IDLE) || w_commit;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_accept)      n_state = S_CMP;
                else if (w_commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= s_axis_tdata[KEY_W-1:0];
            r_pld <= w_in_pld;
            r_ok  <= s_axis_tuser;
        end
    end

    // ---- decision
    assign w_hit    = |w_eq;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_do_ins = !w_hit && r_ok && !w_full;

    assign w_ctl.cmp = (r_state == S_CMP);
    assign w_ctl.ins = w_commit && w_do_ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_ctl.ins) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // ---- cell chain
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev_lt[g] = 1'b1;
            end else begin : g_body
                assign w_prev_lt[g] = w_lt[g-1];
            end

            skcli_cell #(
                .IDX   (g),
                .CNT_W (CNT_W),
                .PW    (PW)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (w_ctl),
                .i_count        (r_count),
                .i_req_key      (r_key),
                .i_req_payload  (r_pld),
                .i_prev_lt      (w_prev_lt[g]),
                .i_prev_key     ((g == 0) ? r_key : w_cell_key[(g == 0) ? 0 : g-1]),
                .i_prev_payload ((g == 0) ? r_pld : w_cell_pld[(g == 0) ? 0 : g-1]),
                .o_lt           (w_lt[g]),
                .o_eq           (w_eq[g]),
                .o_key          (w_cell_key[g]),
                .o_payload      (w_cell_pld[g])
            );
        end
    endgenerate

    // match cell on a hit, insertion point otherwise
    assign w_sel = w_hit ? w_eq : (w_prev_lt & ~w_lt);

    always_comb begin
        w_pos     = '0;
        w_hit_pld = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_sel[i]) w_pos = w_pos | IW'(i);
            w_hit_pld = w_hit_pld | ({PW{w_eq[i]}} & w_cell_pld[i]);
        end
    end

    assign w_res_pld = w_hit ? w_hit_pld : (w_do_ins ? r_pld : '0);

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_flags <= {!w_hit && !w_do_ins, w_do_ins, w_hit};
            r_out_slot  <= (w_hit || w_do_ins) ? w_slot8 : '0;
            r_out_glyph <= w_glyph32;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_flags;
    assign m_axis_tdata  = {r_out_glyph, r_out_slot};

    // ---- checks
    `SKC_ASSERT_IMP(a_eq_onehot0, i_clk, i_rst_n, r_state == S_UPD, $onehot0(w_eq))
    `SKC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SKC_ASSERT_IMP(a_out_flags, i_clk, i_rst_n, r_out_valid, $onehot(r_out_flags))
    `SKC_ASSERT_NXT(a_count_inc, i_clk, i_rst_n, w_ctl.ins,
                    r_count == $past(r_count) + CNT_W'(1))

endmodule

`default_nettype wire

>>> rtl/skcli_cell.sv
// ----------------------------------------------------------------------------
// skcli_cell
// One table slot: holds a key and payload, compares against the request key
// and shifts in from its lower neighbor on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module skcli_cell
    import skcli_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int CNT_W  = 9,
    parameter int PW     = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [KEY_W-1:0] i_req_key,
    input  wire logic [PW-1:0]    i_req_payload,
    input  wire logic             i_prev_lt,
    input  wire logic [KEY_W-1:0] i_prev_key,
    input  wire logic [PW-1:0]    i_prev_payload,
    output logic                  o_lt,
    output logic                  o_eq,
    output logic [KEY_W-1:0]      o_key,
    output logic [PW-1:0]         o_payload
);

    logic [KEY_W-1:0] r_key;
    logic [PW-1:0]    r_payload;
    logic             r_lt;
    logic             r_eq;
    logic             w_valid;

    assign w_valid = (CNT_W'(IDX) < i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= w_valid && (r_key < i_req_key);
            r_eq <= w_valid && (r_key == i_req_key);
        end
    end

    // entries below the insertion point stay, the insertion point loads
    // the new entry, everything above moves up one slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            if (i_prev_lt) begin
                r_key     <= i_req_key;
                r_payload <= i_req_payload;
            end else begin
                r_key     <= i_prev_key;
                r_payload <= i_prev_payload;
            end
        end
    end

    assign o_lt      = r_lt;
    assign o_eq      = r_eq;
    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

`default_nettype wire

>>> tb/tb_sorted_key_cache_lookup_insert.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_key_cache_lookup_insert
// Self-checking bench for the sorted key cache. A directed table covers the
// empty table, the key and payload extremes, hits, failed loads and inserts
// at both ends. Random requests then fill the table to capacity and beyond.
// A shadow copy of the sorted table predicts each result word that a directed
// row does not fix; results are checked in order, all fields in one compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_key_cache_lookup_insert
    import skcli_pkg::*;
();

    localparam int CACHE_DEPTH = 256;
    localparam int PHASE_WORDS = 467;
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AT     = 200;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic               hit;
        logic               inserted;
        logic               use_missing;
        logic [SLOT_W-1:0]  slot;
        logic [GLYPH_W-1:0] glyph;
    } t_lookup_result;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [GLYPH_W-1:0] payload;
        logic               load_ok;
        logic               fixed;
        t_lookup_result     result;
    } t_request_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;    // key[20:0], payload[52:21], zero pad
    logic        s_axis_tuser;    // load_ok
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;    // slot[7:0], glyph_out[39:8]
    logic [2:0]  m_axis_tuser;    // hit, inserted, use_missing

    sorted_key_cache_lookup_insert uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the sorted table
    logic [KEY_W-1:0]   cache_keys   [CACHE_DEPTH];
    logic [GLYPH_W-1:0] cache_glyphs [CACHE_DEPTH];
    int unsigned        cache_count;

    t_lookup_result expected_q[$];

    int unsigned fail_count   = 0;
    int unsigned results_seen = 0;
    int unsigned words_sent   = 0;
    int unsigned n_hit        = 0;
    int unsigned n_insert     = 0;
    int unsigned n_missing    = 0;
    int unsigned n_full       = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    t_request_row directed_rows[13] = '{
        '{21'h000005, 32'h12345678, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 8'd0, 32'h0}},
        '{21'h1FFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 8'd0, 32'hFFFFFFFF}},
        '{21'h000000, 32'h00000000, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 8'd0, 32'h0}},
        '{21'h1FFFFF, 32'hDEADBEEF, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd1, 32'hFFFFFFFF}},
        '{21'h000000, 32'hFFFFFFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0, 32'h0}},
        '{21'h10FFFF, 32'hA5A5A5A5, 1'b1, 1'b0, '0},
        '{21'h110000, 32'h5A5A5A5A, 1'b1, 1'b0, '0},
        '{21'h10FFFF, 32'h00000001, 1'b0, 1'b0, '0},
        '{21'h0FFFFF, 32'h00000002, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 8'd0, 32'h0}},
        '{21'h0FFFFF, 32'h00000001, 1'b1, 1'b0, '0},
        '{21'h000001, 32'h80000000, 1'b1, 1'b0, '0},
        '{21'h1FFFFE, 32'h7FFFFFFF, 1'b1, 1'b0, '0},
        '{21'h110000, 32'h00000000, 1'b1, 1'b0, '0}
    };

    function automatic t_lookup_result lookup_insert(
        input logic [KEY_W-1:0]   key,
        input logic [GLYPH_W-1:0] payload,
        input logic               load_ok
    );
        t_lookup_result res;
        int unsigned    pos;
        res = '0;
        pos = cache_count;
        for (int unsigned i = 0; i < cache_count; i++) begin
            if (cache_keys[i] >= key) begin
                pos = i;
                break;
            end
        end
        if (pos < cache_count && cache_keys[pos] == key) begin
            res.hit   = 1'b1;
            res.slot  = pos[SLOT_W-1:0];
            res.glyph = cache_glyphs[pos];
            n_hit++;
        end else if (!load_ok || cache_count >= CACHE_DEPTH) begin
            res.use_missing = 1'b1;
            n_missing++;
            if (load_ok)
                n_full++;
        end else begin
            for (int unsigned i = cache_count; i > pos; i--) begin
                cache_keys[i]   = cache_keys[i-1];
                cache_glyphs[i] = cache_glyphs[i-1];
            end
            cache_keys[pos]   = key;
            cache_glyphs[pos] = payload;
            cache_count++;
            res.inserted = 1'b1;
            res.slot     = pos[SLOT_W-1:0];
            res.glyph    = payload;
            n_insert++;
        end
        return res;
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    // called just after a falling edge; returns just after the falling edge once the word is taken
    task automatic send_word(
        input logic [KEY_W-1:0]   key,
        input logic [GLYPH_W-1:0] payload,
        input logic               load_ok,
        input bit                 fixed,
        input t_lookup_result     fixed_result
    );
        t_lookup_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, payload, key};
        s_axis_tuser  <= load_ok;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = lookup_insert(key, payload, load_ok);
        expected_q.push_back(fixed ? fixed_result : predicted);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_word();
        logic [KEY_W-1:0] key;
        logic             load_ok;
        if (cache_count != 0 && $urandom_range(99) < 45) begin
            key     = cache_keys[$urandom_range(cache_count - 1)];
            load_ok = 1'($urandom_range(1));
        end else begin
            key     = KEY_W'($urandom_range(21'h1FFFFF));
            load_ok = ($urandom_range(99) < 85);
        end
        send_word(key, $urandom, load_ok, 1'b0, '0);
    endtask

    // result side: ready pattern and one long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        t_lookup_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit         = m_axis_tuser[0];
            got.inserted    = m_axis_tuser[1];
            got.use_missing = m_axis_tuser[2];
            got.slot        = m_axis_tdata[7:0];
            got.glyph       = m_axis_tdata[39:8];
            results_seen++;
            if (expected_q.size() == 0) begin
                note_failure($sformatf(
                    "unexpected word hit=%0b ins=%0b miss=%0b slot=%0d glyph=%h",
                    got.hit, got.inserted, got.use_missing, got.slot, got.glyph));
            end else begin
                want = expected_q.pop_front();
                if (got !== want)
                    note_failure($sformatf({
                        "word %0d: exp hit=%0b ins=%0b miss=%0b slot=%0d glyph=%h, ",
                        "got hit=%0b ins=%0b miss=%0b slot=%0d glyph=%h"},
                        results_seen, want.hit, want.inserted, want.use_missing,
                        want.slot, want.glyph,
                        got.hit, got.inserted, got.use_missing, got.slot, got.glyph));
            end
        end
    end

    initial begin
        #2ms;
        $display("[sorted_key_cache_lookup_insert] ERROR");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cache_count   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct = 38;
        snk_idle_pct = 72;
        foreach (directed_rows[i])
            send_word(directed_rows[i].key, directed_rows[i].payload, directed_rows[i].load_ok,
                      directed_rows[i].fixed, directed_rows[i].result);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 38; snk_idle_pct = 72; end
                1: begin src_idle_pct = 72; snk_idle_pct = 38; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            repeat (PHASE_WORDS)
                send_random_word();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            note_failure($sformatf("%0d result words never arrived", expected_q.size()));

        $display("Sent %0d request words, checked %0d result words; final fill %0d of %0d.",
                 words_sent, results_seen, cache_count, CACHE_DEPTH);
        $display("Hits %0d, inserts %0d, missing glyph %0d (%0d of them on a full table).",
                 n_hit, n_insert, n_missing, n_full);
        if (fail_count == 0) begin
            $display("[sorted_key_cache_lookup_insert] OK");
        end else begin
            $display("%0d failures", fail_count);
            $display("[sorted_key_cache_lookup_insert] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/skcli_pkg.sv
rtl/skcli_cell.sv
rtl/sorted_key_cache_lookup_insert.sv
tb/tb_sorted_key_cache_lookup_insert.sv
